### sv/websocket_frame_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the frame decoder RTL
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DECODER_MACROS_SVH
`define WEBSOCKET_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define WSFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define WSFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and codes of the frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// Header fault codes
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_RESERVED = 2'd1,
		ERR_NO_MASK  = 2'd2,
		ERR_LENGTH   = 2'd3
	} err_t;

	localparam logic [6:0] MAX_LEN = 7'd125;

	// One result of the parser, with a flag telling whether a result exists
	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] data_byte;
		logic [3:0] opcode;
		logic       final_flag;
		logic       last;
		err_t       error_code;
	} wsfd_result_t;

endpackage

### sv/wsfd_if.sv
// ----------------------------------------------------------------------------
// Frame decoder channels
// Valid/ready channels for received bytes and for decoded results.
// ----------------------------------------------------------------------------

// Received byte stream
interface wsfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded results
interface wsfd_tx_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [3:0] opcode;
	logic       final_flag;
	logic       last;
	logic [1:0] error_code;

	modport source (output valid, output kind, output data_byte, output opcode,
		output final_flag, output last, output error_code, input ready);
	modport sink (input valid, input kind, input data_byte, input opcode,
		input final_flag, input last, input error_code, output ready);
endinterface

### sv/wsfd_parser.sv
// ----------------------------------------------------------------------------
// wsfd_parser
// Frame state machine: header, length, masking key, unmasked payload.
// ----------------------------------------------------------------------------
`include "websocket_frame_decoder_macros.svh"

module wsfd_parser
	import wsfd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step_en,
	input  logic [7:0]   rx_byte,
	output wsfd_result_t res
);

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_KEY     = 3'd2,
		PH_PAYLOAD = 3'd3
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [3:0]      opcode_q, opcode_d;
	logic            fin_q, fin_d;
	logic [3:0][7:0] key_q, key_d;
	logic [6:0]      remaining_q, remaining_d;
	logic [1:0]      key_idx_q, key_idx_d;

	// Next state and result for the byte at hand
	always_comb begin
		phase_d     = phase_q;
		opcode_d    = opcode_q;
		fin_d       = fin_q;
		key_d       = key_q;
		remaining_d = remaining_q;
		key_idx_d   = key_idx_q;

		res.valid      = 1'b0;
		res.kind       = KIND_DATA;
		res.data_byte  = 8'd0;
		res.last       = 1'b1;
		res.error_code = ERR_NONE;

		case (phase_q)
			PH_LENGTH: begin
				if (!rx_byte[7]) begin
					phase_d        = PH_HEADER;
					res.valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_NO_MASK;
				end else if (rx_byte[6:0] > MAX_LEN) begin
					phase_d        = PH_HEADER;
					res.valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_LENGTH;
				end else begin
					remaining_d = rx_byte[6:0];
					key_idx_d   = 2'd0;
					phase_d     = PH_KEY;
				end
			end
			PH_KEY: begin
				key_d[key_idx_q] = rx_byte;
				key_idx_d        = key_idx_q + 2'd1;
				if (key_idx_q == 2'd3) begin
					if (remaining_q == 7'd0) begin
						phase_d   = PH_HEADER;
						res.valid = 1'b1;
						res.kind  = KIND_EMPTY;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				key_idx_d     = key_idx_q + 2'd1;
				remaining_d   = remaining_q - 7'd1;
				res.valid     = 1'b1;
				res.kind      = KIND_DATA;
				res.data_byte = rx_byte ^ key_q[key_idx_q];
				res.last      = (remaining_q == 7'd1);
				if (remaining_q == 7'd1) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				// header byte; unused phase codes land here too
				fin_d    = rx_byte[7];
				opcode_d = rx_byte[3:0];
				if (rx_byte[6:4] != 3'd0) begin
					phase_d        = PH_HEADER;
					res.valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_RESERVED;
				end else begin
					phase_d = PH_LENGTH;
				end
			end
		endcase

		// result carries the frame fields as updated by this byte
		res.opcode     = opcode_d;
		res.final_flag = fin_d;
	end

	// State registers, advanced once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			opcode_q    <= 4'd0;
			fin_q       <= 1'b0;
			key_q       <= '0;
			remaining_q <= 7'd0;
			key_idx_q   <= 2'd0;
		end else if (step_en) begin
			phase_q     <= phase_d;
			opcode_q    <= opcode_d;
			fin_q       <= fin_d;
			key_q       <= key_d;
			remaining_q <= remaining_d;
			key_idx_q   <= key_idx_d;
		end
	end

	// Checks
	`WSFD_ASSERT_IMP(a_err_is_last, clk, arst_n, res.valid && res.kind == KIND_ERROR, res.last && res.error_code != ERR_NONE && res.data_byte == 8'd0, "error result malformed")
	`WSFD_ASSERT_NXT(a_key_holds, clk, arst_n, step_en && phase_q == PH_KEY && key_idx_q != 2'd3, phase_q == PH_KEY, "left key phase early")
	`WSFD_ASSERT_NXT(a_payload_end, clk, arst_n, step_en && phase_q == PH_PAYLOAD && remaining_q == 7'd1, phase_q == PH_HEADER, "frame did not end after last byte")

endmodule

### sv/websocket_frame_decoder.sv
// ----------------------------------------------------------------------------
// websocket_frame_decoder
// Unmasks client-to-server frames received one byte at a time.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  rx      | in  | rx_byte[7:0]
//  tx      | out | kind[1:0] data_byte[7:0] opcode[3:0] final_flag last
//          |     | error_code[1:0]
//
//  One byte per cycle unless tx stalls; results come from the result register.
//  Path: rx register, frame state machine, result register.
//  Header, length and key bytes give no result unless the header is faulty
//  or the frame is empty.
//  A stall on tx holds both registers; rx stays ready while the input
//  register is empty or its byte can move on.
//  arst_n clears the frame state and both valid flags.
// ----------------------------------------------------------------------------
`include "websocket_frame_decoder_macros.svh"

module websocket_frame_decoder
	import wsfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	wsfd_rx_if.sink   rx,
	wsfd_tx_if.source tx
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         valid_s2;
	wsfd_result_t res_s2;
	wsfd_result_t res;
	logic         out_free;
	logic         s1_adv;

	assign out_free = !valid_s2 || tx.ready;
	assign s1_adv   = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	wsfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (s1_adv),
		.rx_byte (byte_s1),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= s1_adv && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res.valid) begin
			res_s2 <= res;
		end
	end

	assign tx.valid      = valid_s2;
	assign tx.kind       = res_s2.kind;
	assign tx.data_byte  = res_s2.data_byte;
	assign tx.opcode     = res_s2.opcode;
	assign tx.final_flag = res_s2.final_flag;
	assign tx.last       = res_s2.last;
	assign tx.error_code = res_s2.error_code;

	// Checks
	`WSFD_ASSERT_NXT(a_s1_hold, clk, arst_n, valid_s1 && !s1_adv, valid_s1 && $stable(byte_s1), "stalled byte lost")
	`WSFD_ASSERT_IMP(a_no_overwrite, clk, arst_n, valid_s2 && !tx.ready, !s1_adv, "result register overwritten")
	`WSFD_ASSERT_NXT(a_tx_hold, clk, arst_n, tx.valid && !tx.ready, tx.valid && $stable(res_s2), "stalled result changed")

endmodule
